>>> src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define AAVR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define AAVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// shared constants, types and the cordic arctangent table
// ----------------------------------------------------------------------------
`default_nettype none

package aavr_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int SINCOS_ITER_DEF = 16;
    localparam int ATAN_ENTRIES    = 30;

    // cordic datapath width, q2.30 with headroom
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // stages in the angle reduction pipe
    localparam int ANGLE_LAT = 7;
    // stages in the matrix and dot-product pipe
    localparam int ROT_LAT   = 6;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [17:0] ax;
        logic signed [17:0] ay;
        logic signed [17:0] az;
    } t_geom;

    // arctangent of 2^-idx in binary-angle units, full turn is 2^32
    function automatic logic signed [CW-1:0] atan_turn(input int idx);
        case (idx)
            0:       return 34'sd536870912;
            1:       return 34'sd316933406;
            2:       return 34'sd167458907;
            3:       return 34'sd85004756;
            4:       return 34'sd42667331;
            5:       return 34'sd21354465;
            6:       return 34'sd10679838;
            7:       return 34'sd5340245;
            8:       return 34'sd2670163;
            9:       return 34'sd1335087;
            10:      return 34'sd667544;
            11:      return 34'sd333772;
            12:      return 34'sd166886;
            13:      return 34'sd83443;
            14:      return 34'sd41722;
            15:      return 34'sd20861;
            16:      return 34'sd10430;
            17:      return 34'sd5215;
            18:      return 34'sd2608;
            19:      return 34'sd1304;
            20:      return 34'sd652;
            21:      return 34'sd326;
            22:      return 34'sd163;
            23:      return 34'sd81;
            24:      return 34'sd41;
            25:      return 34'sd20;
            26:      return 34'sd10;
            27:      return 34'sd5;
            28:      return 34'sd3;
            29:      return 34'sd1;
            default: return 34'sd0;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> src/aavr_angle.sv
// ----------------------------------------------------------------------------
// aavr_angle
// degrees modulo 360 to a 32-bit binary angle, folded into [-90, 90] degrees
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_angle
    import aavr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_angle,
    output logic                    o_valid,
    output logic signed [31:0]      o_z,
    output logic                    o_neg
);

    localparam int HW = 32 - FRAC_BITS;
    localparam int SW = 32 - FRAC_BITS;
    // offset keeps the integer degrees positive, a multiple of 360
    localparam logic [24:0] HI_OFS    = 25'd11796480;
    localparam logic [25:0] RECIP_360 = 26'd47721858;  // floor(2^34/360)
    localparam logic [22:0] RECIP_45  = 23'd5965232;   // floor(2^28/45)

    logic [ANGLE_LAT-1:0] r_v;

    logic [24:0]           r1_u;
    logic [FRAC_BITS-1:0]  r1_lo;
    logic [16:0]           r2_q;
    logic [24:0]           r2_u;
    logic [FRAC_BITS-1:0]  r2_lo;
    logic [8:0]            r3_rhi;
    logic [FRAC_BITS-1:0]  r3_lo;
    logic [16:0]           r4_qe;
    logic [21:0]           r4_yh;
    logic [15:0]           r4_yl;
    logic [15:0]           r5_qh;
    logic [5:0]            r5_rh;
    logic [15:0]           r5_yl;
    logic [16:0]           r6_qe;
    logic [21:0]           r6_v;
    logic [15:0]           r6_qh;
    logic signed [31:0]    r7_z;
    logic                  r7_neg;

    logic signed [HW-1:0]  w_hi;
    logic [24:0]           w_u;
    logic [50:0]           w_p360;
    logic [25:0]           w_qm;
    logic [25:0]           w_rm;
    logic [8:0]            w_rhi;
    logic [40:0]           w_x;
    logic [44:0]           w_p45a;
    logic [21:0]           w_rema;
    logic [15:0]           w_qh;
    logic [5:0]            w_rh;
    logic [21:0]           w_v;
    logic [44:0]           w_p45b;
    logic [21:0]           w_remb;
    logic [16:0]           w_ql;
    logic signed [32:0]    w_zs;
    logic signed [32:0]    w_zf;
    logic                  w_neg;

    always_comb begin
        w_hi   = i_angle[31:FRAC_BITS];
        w_u    = {{(25-HW){w_hi[HW-1]}}, w_hi} + HI_OFS;
        w_p360 = 51'(r1_u) * 51'(RECIP_360);
        w_qm   = 26'(r2_q) * 26'd360;
        w_rm   = 26'(r2_u) - w_qm;
        w_rhi  = (w_rm[9:0] >= 10'd360) ? 9'(w_rm[9:0] - 10'd360) : w_rm[8:0];
        w_x    = {r3_rhi, r3_lo, {SW{1'b0}}};
        w_p45a = 45'(w_x[40:19]) * 45'(RECIP_45);
        w_rema = r4_yh - 22'(22'(r4_qe) * 22'd45);
        if (w_rema >= 22'd45) begin
            w_qh = 16'(r4_qe + 17'd1);
            w_rh = 6'(w_rema - 22'd45);
        end else begin
            w_qh = r4_qe[15:0];
            w_rh = w_rema[5:0];
        end
        w_v    = {r5_rh, r5_yl};
        w_p45b = 45'(w_v) * 45'(RECIP_45);
        w_remb = r6_v - 22'(22'(r6_qe) * 22'd45);
        w_ql   = (w_remb >= 22'd45) ? r6_qe + 17'd1 : r6_qe;
        w_zs   = 33'(signed'({r6_qh, w_ql[15:0]}));
        // outside the right half-plane: turn by half a turn, negate later
        if (w_zs > 33'sd1073741824) begin
            w_zf  = w_zs - 33'sd2147483648;
            w_neg = 1'b1;
        end else if (w_zs < -33'sd1073741824) begin
            w_zf  = w_zs + 33'sd2147483648;
            w_neg = 1'b1;
        end else begin
            w_zf  = w_zs;
            w_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ANGLE_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_u   <= w_u;
            r1_lo  <= i_angle[FRAC_BITS-1:0];
            r2_q   <= w_p360[50:34];
            r2_u   <= r1_u;
            r2_lo  <= r1_lo;
            r3_rhi <= w_rhi;
            r3_lo  <= r2_lo;
            r4_qe  <= w_p45a[44:28];
            r4_yh  <= w_x[40:19];
            r4_yl  <= w_x[18:3];
            r5_qh  <= w_qh;
            r5_rh  <= w_rh;
            r5_yl  <= r4_yl;
            r6_qe  <= w_p45b[44:28];
            r6_v   <= w_v;
            r6_qh  <= r5_qh;
            r7_z   <= w_zf[31:0];
            r7_neg <= w_neg;
        end
    end

    assign o_valid = r_v[ANGLE_LAT-1];
    assign o_z     = r7_z;
    assign o_neg   = r7_neg;

endmodule

`default_nettype wire

>>> src/aavr_cordic.sv
// ----------------------------------------------------------------------------
// aavr_cordic
// rotation-mode cordic, one register stage per step, sine and cosine in q2.30
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_cordic
    import aavr_pkg::*;
#(
    parameter int SINCOS_ITERATIONS = SINCOS_ITER_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_z,
    input  wire logic               i_neg,
    output logic                    o_valid,
    output logic signed [CW-1:0]    o_sin,
    output logic signed [CW-1:0]    o_cos
);

    localparam int NI = (SINCOS_ITERATIONS < ATAN_ENTRIES) ? SINCOS_ITERATIONS
                                                            : ATAN_ENTRIES;

    logic signed [CW-1:0] w_x [NI+1];
    logic signed [CW-1:0] w_y [NI+1];
    logic signed [CW-1:0] w_z [NI+1];
    logic                 w_neg [NI+1];
    logic                 w_v [NI+1];

    logic                 r_v;
    logic signed [CW-1:0] r_sin;
    logic signed [CW-1:0] r_cos;

    assign w_x[0]   = CORDIC_GAIN;
    assign w_y[0]   = '0;
    assign w_z[0]   = CW'(i_z);
    assign w_neg[0] = i_neg;
    assign w_v[0]   = i_valid;

    for (genvar g = 0; g < NI; g++) begin : g_step
        logic signed [CW-1:0] r_x;
        logic signed [CW-1:0] r_y;
        logic signed [CW-1:0] r_z;
        logic                 r_neg;
        logic                 r_sv;
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;

        assign w_xs = w_x[g] >>> g;
        assign w_ys = w_y[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv <= 1'b0;
            end else if (i_en) begin
                r_sv <= w_v[g];
            end
        end

        // zero residual counts as positive
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg <= w_neg[g];
                if (!w_z[g][CW-1]) begin
                    r_x <= w_x[g] - w_ys;
                    r_y <= w_y[g] + w_xs;
                    r_z <= w_z[g] - atan_turn(g);
                end else begin
                    r_x <= w_x[g] + w_ys;
                    r_y <= w_y[g] - w_xs;
                    r_z <= w_z[g] + atan_turn(g);
                end
            end
        end

        assign w_x[g+1]   = r_x;
        assign w_y[g+1]   = r_y;
        assign w_z[g+1]   = r_z;
        assign w_neg[g+1] = r_neg;
        assign w_v[g+1]   = r_sv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= w_v[NI];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= w_neg[NI] ? -w_x[NI] : w_x[NI];
            r_sin <= w_neg[NI] ? -w_y[NI] : w_y[NI];
        end
    end

    assign o_valid = r_v;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

`default_nettype wire

>>> src/aavr_rotate.sv
// ----------------------------------------------------------------------------
// aavr_rotate
// builds the rotation matrix from sine, cosine and axis, then rotates the vector
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_rotate
    import aavr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic signed [CW-1:0] i_sin,
    input  wire logic signed [CW-1:0] i_cos,
    input  wire t_geom              i_geom,
    output logic                    o_valid,
    output logic signed [31:0]      o_rx,
    output logic signed [31:0]      o_ry,
    output logic signed [31:0]      o_rz,
    output logic                    o_sat
);

    localparam int TW   = CW + 1;
    localparam int PPW  = 37 - FRAC_BITS;
    localparam int SPW  = CW + 18;
    localparam int SAW  = SPW + 1 - FRAC_BITS;
    localparam int TTW  = TW + PPW;
    localparam int TTSW = TTW - FRAC_BITS;
    localparam int EW0  = (TTSW > SAW) ? TTSW : SAW;
    localparam int EW   = ((EW0 > CW) ? EW0 : CW) + 2;

    localparam logic signed [EW-1:0] E_ONE  = EW'(64'sd1073741824);
    localparam logic signed [EW-1:0] E_MONE = EW'(-64'sd1073741824);

    function automatic logic signed [31:0] clamp_one(input logic signed [EW-1:0] v);
        if (v > E_ONE) begin
            return 32'sd1073741824;
        end else if (v < E_MONE) begin
            return -32'sd1073741824;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [PPW-1:0] axis_pp(input logic signed [17:0] a,
                                                      input logic signed [17:0] b);
        logic signed [35:0] m;
        logic signed [35:0] s;
        m = 36'(a) * 36'(b);
        s = m >>> FRAC_BITS;
        return s[PPW-1:0];
    endfunction

    function automatic logic signed [SAW-1:0] sin_axis(input logic signed [CW-1:0] sv,
                                                       input logic signed [17:0] a);
        logic signed [SPW-1:0] m;
        logic signed [SPW-1:0] s;
        m = SPW'(sv) * SPW'(a);
        s = m >>> FRAC_BITS;
        return s[SAW-1:0];
    endfunction

    function automatic logic signed [TTSW-1:0] t_term(input logic signed [TW-1:0] t,
                                                      input logic signed [PPW-1:0] p);
        logic signed [TTW-1:0] m;
        logic signed [TTW-1:0] s;
        m = TTW'(t) * TTW'(p);
        s = m >>> FRAC_BITS;
        return s[TTSW-1:0];
    endfunction

    logic [ROT_LAT-1:0] r_v;

    // stage 1
    logic signed [TW-1:0]   r1_t;
    logic signed [CW-1:0]   r1_c;
    logic signed [PPW-1:0]  r1_pxx, r1_pxy, r1_pxz, r1_pyy, r1_pyz, r1_pzz;
    logic signed [SAW-1:0]  r1_sx, r1_sy, r1_sz;
    t_geom                  r1_g;
    // stage 2
    logic signed [CW-1:0]   r2_c;
    logic signed [TTSW-1:0] r2_txx, r2_txy, r2_txz, r2_tyy, r2_tyz, r2_tzz;
    logic signed [SAW-1:0]  r2_sx, r2_sy, r2_sz;
    t_geom                  r2_g;
    // stage 3
    logic signed [31:0]     r3_e [9];
    t_geom                  r3_g;
    // stage 4
    logic signed [63:0]     r4_p [9];
    // stage 5
    logic signed [65:0]     r5_acc [3];
    // stage 6
    logic signed [31:0]     r6_r [3];
    logic                   r6_sat;

    logic signed [EW-1:0]   w_c, w_txx, w_txy, w_txz, w_tyy, w_tyz, w_tzz;
    logic signed [EW-1:0]   w_sx, w_sy, w_sz;
    logic signed [35:0]     w_res [3];
    logic signed [31:0]     w_r [3];
    logic [2:0]             w_clip;

    always_comb begin
        w_c   = EW'(r2_c);
        w_txx = EW'(r2_txx);
        w_txy = EW'(r2_txy);
        w_txz = EW'(r2_txz);
        w_tyy = EW'(r2_tyy);
        w_tyz = EW'(r2_tyz);
        w_tzz = EW'(r2_tzz);
        w_sx  = EW'(r2_sx);
        w_sy  = EW'(r2_sy);
        w_sz  = EW'(r2_sz);
        for (int k = 0; k < 3; k++) begin
            w_res[k] = 36'(r5_acc[k] >>> 30);
            if (w_res[k] > 36'sd2147483647) begin
                w_r[k]    = 32'sh7fffffff;
                w_clip[k] = 1'b1;
            end else if (w_res[k] < -36'sd2147483648) begin
                w_r[k]    = 32'sh80000000;
                w_clip[k] = 1'b1;
            end else begin
                w_r[k]    = w_res[k][31:0];
                w_clip[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ROT_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t   <= TW'(35'sd1073741824 - TW'(i_cos));
            r1_c   <= i_cos;
            r1_pxx <= axis_pp(i_geom.ax, i_geom.ax);
            r1_pxy <= axis_pp(i_geom.ax, i_geom.ay);
            r1_pxz <= axis_pp(i_geom.ax, i_geom.az);
            r1_pyy <= axis_pp(i_geom.ay, i_geom.ay);
            r1_pyz <= axis_pp(i_geom.ay, i_geom.az);
            r1_pzz <= axis_pp(i_geom.az, i_geom.az);
            r1_sx  <= sin_axis(i_sin, i_geom.ax);
            r1_sy  <= sin_axis(i_sin, i_geom.ay);
            r1_sz  <= sin_axis(i_sin, i_geom.az);
            r1_g   <= i_geom;

            r2_c   <= r1_c;
            r2_txx <= t_term(r1_t, r1_pxx);
            r2_txy <= t_term(r1_t, r1_pxy);
            r2_txz <= t_term(r1_t, r1_pxz);
            r2_tyy <= t_term(r1_t, r1_pyy);
            r2_tyz <= t_term(r1_t, r1_pyz);
            r2_tzz <= t_term(r1_t, r1_pzz);
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_sz  <= r1_sz;
            r2_g   <= r1_g;

            // row-major matrix entries, clamped to plus or minus one
            r3_e[0] <= clamp_one(w_c + w_txx);
            r3_e[1] <= clamp_one(w_txy - w_sz);
            r3_e[2] <= clamp_one(w_txz + w_sy);
            r3_e[3] <= clamp_one(w_txy + w_sz);
            r3_e[4] <= clamp_one(w_c + w_tyy);
            r3_e[5] <= clamp_one(w_tyz - w_sx);
            r3_e[6] <= clamp_one(w_txz - w_sy);
            r3_e[7] <= clamp_one(w_tyz + w_sx);
            r3_e[8] <= clamp_one(w_c + w_tzz);
            r3_g    <= r2_g;

            for (int k = 0; k < 3; k++) begin
                r4_p[3*k]   <= 64'(r3_e[3*k])   * 64'(r3_g.vx);
                r4_p[3*k+1] <= 64'(r3_e[3*k+1]) * 64'(r3_g.vy);
                r4_p[3*k+2] <= 64'(r3_e[3*k+2]) * 64'(r3_g.vz);
                r5_acc[k]   <= 66'(r4_p[3*k]) + 66'(r4_p[3*k+1]) + 66'(r4_p[3*k+2])
                               + 66'sd536870912;
                r6_r[k]     <= w_r[k];
            end
            r6_sat <= |w_clip;
        end
    end

    assign o_valid = r_v[ROT_LAT-1];
    assign o_rx    = r6_r[0];
    assign o_ry    = r6_r[1];
    assign o_rz    = r6_r[2];
    assign o_sat   = r6_sat;

endmodule

`default_nettype wire

>>> src/axis_angle_vector_rotate.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate
// rotates a q16.16 vector about a unit axis by an angle in degrees
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                   per beat
//  s_axis   in         vec x/y/z, axis x/y/z, angle_deg          one item
//  m_axis   out        rot x/y/z in tdata, saturated in tuser    one result
//
// one beat in each cycle sustained while the skid register is empty, one result beat per input beat
// the stages in order (cordic steps capped at 30):
//   7 angle reduction stages, one per cordic step plus a sign stage,
//   6 matrix and dot-product stages and the output register
// reset is synchronous, active low, and clears only the valid bits
// when the output is stalled one result parks in a skid register; the pipe
// then halts as a whole and nothing is dropped or repeated
//
`default_nettype none

`include "assert_macros.svh"

module axis_angle_vector_rotate
    import aavr_pkg::*;
#(
    parameter int FRAC_BITS         = FRAC_BITS_DEF,
    parameter int SINCOS_ITERATIONS = SINCOS_ITER_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // vec_x, vec_y, vec_z (32 each), axis_x, axis_y, axis_z (18 each),
    // angle_deg (32), two zero pad bits
    input  wire logic [183:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // rot_x, rot_y, rot_z (32 each)
    output logic [95:0]       o_m_axis_tdata,
    // saturated
    output logic [0:0]        o_m_axis_tuser
);

    localparam int NI  = (SINCOS_ITERATIONS < ATAN_ENTRIES) ? SINCOS_ITERATIONS
                                                             : ATAN_ENTRIES;
    // geometry waits alongside the angle and cordic pipes
    localparam int DLY = ANGLE_LAT + NI + 1;

    logic                 w_en;
    t_geom                w_in_geom;
    logic                 w_ang_v;
    logic signed [31:0]   w_ang_z;
    logic                 w_ang_neg;
    logic                 w_sc_v;
    logic signed [CW-1:0] w_sin;
    logic signed [CW-1:0] w_cos;
    logic                 w_end_v;
    logic signed [31:0]   w_rx, w_ry, w_rz;
    logic                 w_sat;

    t_geom                r_dly [DLY];

    logic                 r_out_valid;
    logic signed [31:0]   r_out_rx, r_out_ry, r_out_rz;
    logic                 r_out_sat;
    logic                 r_skid_valid;
    logic signed [31:0]   r_skid_rx, r_skid_ry, r_skid_rz;
    logic                 r_skid_sat;

    // whole pipe advances unless the skid register is holding a result
    assign w_en            = !r_skid_valid;
    assign o_s_axis_tready = w_en;

    assign w_in_geom.vx = i_s_axis_tdata[31:0];
    assign w_in_geom.vy = i_s_axis_tdata[63:32];
    assign w_in_geom.vz = i_s_axis_tdata[95:64];
    assign w_in_geom.ax = i_s_axis_tdata[113:96];
    assign w_in_geom.ay = i_s_axis_tdata[131:114];
    assign w_in_geom.az = i_s_axis_tdata[149:132];

    aavr_angle #(
        .FRAC_BITS (FRAC_BITS)
    ) u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_angle (i_s_axis_tdata[181:150]),
        .o_valid (w_ang_v),
        .o_z     (w_ang_z),
        .o_neg   (w_ang_neg)
    );

    aavr_cordic #(
        .SINCOS_ITERATIONS (SINCOS_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ang_v),
        .i_z     (w_ang_z),
        .i_neg   (w_ang_neg),
        .o_valid (w_sc_v),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // geometry delay line, a single tap at its last register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= w_in_geom;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    aavr_rotate #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sc_v),
        .i_sin   (w_sin),
        .i_cos   (w_cos),
        .i_geom  (r_dly[DLY-1]),
        .o_valid (w_end_v),
        .o_rx    (w_rx),
        .o_ry    (w_ry),
        .o_rz    (w_rz),
        .o_sat   (w_sat)
    );

    // output register with one-entry skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_end_v;
            end
        end else if (w_end_v && w_en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_rx  <= r_skid_rx;
                r_out_ry  <= r_skid_ry;
                r_out_rz  <= r_skid_rz;
                r_out_sat <= r_skid_sat;
            end else begin
                r_out_rx  <= w_rx;
                r_out_ry  <= w_ry;
                r_out_rz  <= w_rz;
                r_out_sat <= w_sat;
            end
        end else if (w_en) begin
            r_skid_rx  <= w_rx;
            r_skid_ry  <= w_ry;
            r_skid_rz  <= w_rz;
            r_skid_sat <= w_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_rz, r_out_ry, r_out_rx};
    assign o_m_axis_tuser  = r_out_sat;

    // skid only ever holds a result behind a full output register
    `AAVR_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with output empty")

    // a result reaching a stalled output must be parked, not lost
    `AAVR_ASSERT_NEXT(a_stall_parks, i_clk, i_rst_n, w_end_v && w_en && r_out_valid && !i_m_axis_tready, r_skid_valid, "result dropped at stalled output")

    // the clip flag means some component sits at a rail
    `AAVR_ASSERT_NOW(a_sat_at_rail, i_clk, i_rst_n, r_out_valid && r_out_sat, r_out_rx == 32'sh7fffffff || r_out_rx == 32'sh80000000 || r_out_ry == 32'sh7fffffff || r_out_ry == 32'sh80000000 || r_out_rz == 32'sh7fffffff || r_out_rz == 32'sh80000000, "saturated flag without clipped component")

endmodule

`default_nettype wire
